// File: rtl/core/scbar_pkg.sv
package scbar_pkg;

    localparam int CHANNELS      = 6;
    localparam int ADC_BITS      = 24;
    localparam int DISCARD_LSBS  = 6;
    localparam int CALIB_SAMPLES = 100;

    localparam int SAMPLE_W  = ADC_BITS - DISCARD_LSBS;
    localparam int VALUE_W   = SAMPLE_W + 1;
    localparam int ACC_W     = SAMPLE_W + $clog2(CALIB_SAMPLES);
    localparam int BIT_IDX_W = $clog2(ADC_BITS + 2);

    localparam int     DIV_SHIFT = ACC_W + $clog2(CALIB_SAMPLES) - 1;
    localparam longint DIV_MULT  = ((64'd1 << DIV_SHIFT) + CALIB_SAMPLES - 1) / CALIB_SAMPLES;
    localparam int     MULT_W    = $clog2(DIV_MULT + 1);

    localparam int WAIT_W     = 10;
    localparam int MS_W       = 10;
    localparam int ERR_W      = 8;
    localparam int SKIP_W     = 8;
    localparam int PULSE_W    = 8;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 10;
    localparam int STATUS_W   = 2;

    localparam logic [STATUS_W-1:0] ST_RUN  = 2'd0;
    localparam logic [STATUS_W-1:0] ST_CAL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FAIL = 2'd2;

    typedef logic signed [VALUE_W-1:0] value_t;

    typedef struct packed {
        logic clear_shift;
        logic shift_en;
        logic finish;
        logic zero_cal;
        logic acc_add;
        logic load_offset;
    } lane_ctl_t;

    typedef struct packed {
        logic                        sclk;
        value_t [CHANNELS-1:0]       values;
        logic                        data_updated;
        logic [STATUS_W-1:0]         status;
    } result_t;

endpackage

// File: rtl/core/scbar_lane.sv
module scbar_lane (
    input  logic                 clk,
    input  logic                 rst_n,
    input  scbar_pkg::lane_ctl_t ctl,
    input  logic                 pin,
    output logic                 line_low,
    output scbar_pkg::value_t    value_next
);

    logic        [scbar_pkg::ADC_BITS-1:0]                  shift_reg;
    logic        [scbar_pkg::ADC_BITS-1:0]                  shift_next;
    logic signed [scbar_pkg::SAMPLE_W-1:0]                  sample_reg;
    logic signed [scbar_pkg::SAMPLE_W-1:0]                  sample_next;
    logic signed [scbar_pkg::SAMPLE_W-1:0]                  offset_reg;
    logic signed [scbar_pkg::SAMPLE_W-1:0]                  offset_next;
    logic signed [scbar_pkg::SAMPLE_W-1:0]                  raw_sample;
    logic signed [scbar_pkg::SAMPLE_W-1:0]                  avg;
    logic signed [scbar_pkg::ACC_W-1:0]                     acc_reg;
    logic signed [scbar_pkg::ACC_W-1:0]                     acc_next;
    logic signed [scbar_pkg::ACC_W-1:0]                     raw_ext;
    logic signed [scbar_pkg::ACC_W-1:0]                     sum;
    logic        [scbar_pkg::ACC_W-1:0]                     mag_reg;
    logic                                                   neg_reg;
    logic                                                   neg2_reg;
    logic        [scbar_pkg::MULT_W-1:0]                    div_k;
    logic        [scbar_pkg::ACC_W+scbar_pkg::MULT_W-1:0]   prod_reg;
    logic        [scbar_pkg::SAMPLE_W-1:0]                  quot;
    logic signed [scbar_pkg::VALUE_W-1:0]                   sample_ext;
    logic signed [scbar_pkg::VALUE_W-1:0]                   offset_ext;

    assign line_low   = ~pin;
    assign raw_sample = $signed(shift_reg[scbar_pkg::ADC_BITS-1 -: scbar_pkg::SAMPLE_W]);
    assign raw_ext    = $signed({{(scbar_pkg::ACC_W-scbar_pkg::SAMPLE_W){raw_sample[scbar_pkg::SAMPLE_W-1]}},
                                 raw_sample});
    assign sum        = acc_reg + raw_ext;
    assign div_k      = scbar_pkg::MULT_W'(scbar_pkg::DIV_MULT);
    assign quot       = prod_reg[scbar_pkg::DIV_SHIFT +: scbar_pkg::SAMPLE_W];
    assign avg        = neg2_reg ? -$signed(quot) : $signed(quot);

    // average pipeline: the sum's magnitude and sign are registered, then the reciprocal product
    always_ff @(posedge clk)
    begin
        mag_reg  <= sum[scbar_pkg::ACC_W-1] ? $unsigned(-sum) : $unsigned(sum);
        neg_reg  <= sum[scbar_pkg::ACC_W-1];
        prod_reg <= mag_reg * div_k;
        neg2_reg <= neg_reg;
    end

    always_comb
    begin
        if (ctl.clear_shift)
        begin
            shift_next = '0;
        end
        else if (ctl.shift_en)
        begin
            shift_next = {shift_reg[scbar_pkg::ADC_BITS-2:0], pin};
        end
        else
        begin
            shift_next = shift_reg;
        end

        sample_next = ctl.finish ? raw_sample : sample_reg;

        acc_next = ctl.zero_cal ? '0 : acc_reg;
        if (ctl.acc_add)
        begin
            acc_next = acc_next + raw_ext;
        end

        if (ctl.load_offset)
        begin
            offset_next = avg;
        end
        else if (ctl.zero_cal)
        begin
            offset_next = '0;
        end
        else
        begin
            offset_next = offset_reg;
        end

        sample_ext = $signed({sample_next[scbar_pkg::SAMPLE_W-1], sample_next});
        offset_ext = $signed({offset_next[scbar_pkg::SAMPLE_W-1], offset_next});
        value_next = sample_ext - offset_ext;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg  <= '0;
            sample_reg <= '0;
            offset_reg <= '0;
            acc_reg    <= '0;
        end
        else
        begin
            shift_reg  <= shift_next;
            sample_reg <= sample_next;
            offset_reg <= offset_next;
            acc_reg    <= acc_next;
        end
    end

endmodule

// File: rtl/core/scbar_seq.sv
module scbar_seq (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [scbar_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [scbar_pkg::CFG_DATA_W-1:0]    cfg_wdata,
    input  logic                                fire,
    input  logic                                all_low,
    input  logic                                edge_seen,
    input  logic                                ms_tick,
    input  logic                                read_ack,
    input  logic                                calibrate,
    output scbar_pkg::lane_ctl_t                ctl,
    output logic                                sclk_next,
    output logic                                data_updated_next,
    output logic [scbar_pkg::STATUS_W-1:0]      status_next
);

    localparam logic [2:0] PH_IDLE    = 3'd0;
    localparam logic [2:0] PH_WAIT    = 3'd1;
    localparam logic [2:0] PH_LOW     = 3'd2;
    localparam logic [2:0] PH_HIGH    = 3'd3;
    localparam logic [2:0] PH_TAIL    = 3'd4;
    localparam logic [2:0] PH_PWR_OFF = 3'd5;
    localparam logic [2:0] PH_FAILED  = 3'd6;

    localparam logic [1:0] CAL_NONE = 2'd0;
    localparam logic [1:0] CAL_SKIP = 2'd1;
    localparam logic [1:0] CAL_AVG  = 2'd2;

    localparam logic [scbar_pkg::CFG_IDX_W-1:0] CFG_WAIT_TIMEOUT = 3'd0;
    localparam logic [scbar_pkg::CFG_IDX_W-1:0] CFG_READ_TIMEOUT = 3'd1;
    localparam logic [scbar_pkg::CFG_IDX_W-1:0] CFG_MAX_ERRORS   = 3'd2;
    localparam logic [scbar_pkg::CFG_IDX_W-1:0] CFG_SKIP_SAMPLES = 3'd3;
    localparam logic [scbar_pkg::CFG_IDX_W-1:0] CFG_PULSE_CYCLES = 3'd4;

    localparam logic [scbar_pkg::WAIT_W-1:0]  WAIT_TIMEOUT_RST = 10'd50;
    localparam logic [scbar_pkg::MS_W-1:0]    READ_TIMEOUT_RST = 10'd200;
    localparam logic [scbar_pkg::ERR_W-1:0]   MAX_ERRORS_RST   = 8'd10;
    localparam logic [scbar_pkg::SKIP_W-1:0]  SKIP_SAMPLES_RST = 8'd50;
    localparam logic [scbar_pkg::PULSE_W-1:0] PULSE_CYCLES_RST = 8'd120;

    localparam logic [scbar_pkg::MS_W-1:0]  MS_MAX  = '1;
    localparam logic [scbar_pkg::ERR_W-1:0] ERR_MAX = '1;
    localparam logic [scbar_pkg::ERR_W-1:0] CALIB_TARGET = scbar_pkg::ERR_W'(scbar_pkg::CALIB_SAMPLES);

    logic [scbar_pkg::WAIT_W-1:0]    wait_timeout_reg;
    logic [scbar_pkg::MS_W-1:0]      read_timeout_reg;
    logic [scbar_pkg::ERR_W-1:0]     max_errors_reg;
    logic [scbar_pkg::SKIP_W-1:0]    skip_samples_reg;
    logic [scbar_pkg::PULSE_W-1:0]   pulse_cycles_reg;

    logic [2:0]                      phase_reg, phase_next;
    logic [scbar_pkg::BIT_IDX_W-1:0] bit_index_reg, bit_index_next;
    logic [scbar_pkg::PULSE_W-1:0]   pulse_timer_reg, pulse_timer_next;
    logic [scbar_pkg::WAIT_W-1:0]    wait_timer_reg, wait_timer_next;
    logic [scbar_pkg::MS_W-1:0]      since_read_reg, since_read_next;
    logic [scbar_pkg::ERR_W-1:0]     error_count_reg, error_count_next;
    logic [scbar_pkg::SKIP_W-1:0]    calib_count_reg, calib_count_next;
    logic [1:0]                      calib_phase_reg, calib_phase_next;
    logic                            updated_reg, updated_next;
    logic                            pending_reg, pending_next;

    logic [scbar_pkg::PULSE_W:0]     pulse_inc;
    logic                            pulse_done;
    scbar_pkg::lane_ctl_t            ctl_c;

    assign pulse_inc  = {1'b0, pulse_timer_reg} + 1'b1;
    assign pulse_done = pulse_inc >= {1'b0, pulse_cycles_reg};

    always_comb
    begin
        phase_next       = phase_reg;
        bit_index_next   = bit_index_reg;
        pulse_timer_next = pulse_timer_reg;
        wait_timer_next  = wait_timer_reg;
        since_read_next  = since_read_reg;
        error_count_next = error_count_reg;
        calib_count_next = calib_count_reg;
        calib_phase_next = calib_phase_reg;
        updated_next     = updated_reg;
        pending_next     = pending_reg;
        ctl_c            = '0;

        if (read_ack)
        begin
            updated_next = 1'b0;
        end

        if (phase_reg != PH_FAILED && error_count_reg >= max_errors_reg)
        begin
            phase_next       = PH_FAILED;
            calib_phase_next = CAL_NONE;
        end

        if (phase_next != PH_FAILED)
        begin
            if (calibrate && calib_phase_next == CAL_NONE)
            begin
                calib_count_next = '0;
                if (skip_samples_reg == '0)
                begin
                    calib_phase_next = CAL_AVG;
                    ctl_c.zero_cal   = 1'b1;
                end
                else
                begin
                    calib_phase_next = CAL_SKIP;
                end
            end

            if (edge_seen && phase_next != PH_WAIT && phase_next != PH_PWR_OFF)
            begin
                pending_next = 1'b1;
            end

            unique case (phase_next)
                PH_IDLE:
                begin
                    if (pending_next)
                    begin
                        pending_next    = 1'b0;
                        wait_timer_next = '0;
                        phase_next      = PH_WAIT;
                    end
                end
                PH_WAIT:
                begin
                    if (all_low)
                    begin
                        ctl_c.clear_shift = 1'b1;
                        bit_index_next    = '0;
                        pulse_timer_next  = '0;
                        phase_next        = PH_LOW;
                    end
                    else if (ms_tick)
                    begin
                        wait_timer_next = wait_timer_reg + 1'b1;
                        if (wait_timer_next >= wait_timeout_reg)
                        begin
                            phase_next = PH_IDLE;
                        end
                    end
                end
                PH_LOW:
                begin
                    pulse_timer_next = pulse_done ? '0 : pulse_inc[scbar_pkg::PULSE_W-1:0];
                    if (pulse_done)
                    begin
                        phase_next = PH_HIGH;
                    end
                end
                PH_HIGH:
                begin
                    pulse_timer_next = pulse_done ? '0 : pulse_inc[scbar_pkg::PULSE_W-1:0];
                    if (pulse_done)
                    begin
                        if (bit_index_reg < scbar_pkg::BIT_IDX_W'(scbar_pkg::ADC_BITS))
                        begin
                            ctl_c.shift_en = 1'b1;
                        end
                        bit_index_next = bit_index_reg + 1'b1;
                        phase_next = (bit_index_next > scbar_pkg::BIT_IDX_W'(scbar_pkg::ADC_BITS))
                                     ? PH_TAIL : PH_LOW;
                    end
                end
                PH_TAIL:
                begin
                    pulse_timer_next = pulse_done ? '0 : pulse_inc[scbar_pkg::PULSE_W-1:0];
                    if (pulse_done)
                    begin
                        ctl_c.finish     = 1'b1;
                        error_count_next = '0;
                        since_read_next  = '0;
                        phase_next       = PH_IDLE;
                        unique case (calib_phase_next)
                            CAL_SKIP:
                            begin
                                calib_count_next = calib_count_next + 1'b1;
                                if (calib_count_next >= skip_samples_reg)
                                begin
                                    calib_phase_next = CAL_AVG;
                                    calib_count_next = '0;
                                    ctl_c.zero_cal   = 1'b1;
                                end
                            end
                            CAL_AVG:
                            begin
                                ctl_c.acc_add    = 1'b1;
                                calib_count_next = calib_count_next + 1'b1;
                                if (calib_count_next >= CALIB_TARGET)
                                begin
                                    ctl_c.load_offset = 1'b1;
                                    calib_phase_next  = CAL_NONE;
                                    calib_count_next  = '0;
                                end
                            end
                            default:
                            begin
                                updated_next = 1'b1;
                            end
                        endcase
                    end
                end
                PH_PWR_OFF:
                begin
                    if (ms_tick)
                    begin
                        phase_next = PH_IDLE;
                    end
                end
                default:
                begin
                    phase_next = PH_FAILED;
                end
            endcase

            if (ms_tick)
            begin
                if (since_read_next >= read_timeout_reg)
                begin
                    since_read_next  = '0;
                    if (error_count_next != ERR_MAX)
                    begin
                        error_count_next = error_count_next + 1'b1;
                    end
                    pulse_timer_next = '0;
                    if (error_count_next >= max_errors_reg)
                    begin
                        phase_next       = PH_FAILED;
                        calib_phase_next = CAL_NONE;
                    end
                    else
                    begin
                        phase_next = PH_PWR_OFF;
                    end
                end
                else if (since_read_next != MS_MAX)
                begin
                    since_read_next = since_read_next + 1'b1;
                end
            end
        end
    end

    assign ctl               = fire ? ctl_c : '0;
    assign sclk_next         = (phase_next == PH_HIGH) || (phase_next == PH_PWR_OFF)
                               || (phase_next == PH_FAILED);
    assign data_updated_next = updated_next;
    assign status_next       = (phase_next == PH_FAILED) ? scbar_pkg::ST_FAIL
                             : (calib_phase_next != CAL_NONE) ? scbar_pkg::ST_CAL
                             : scbar_pkg::ST_RUN;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wait_timeout_reg <= WAIT_TIMEOUT_RST;
            read_timeout_reg <= READ_TIMEOUT_RST;
            max_errors_reg   <= MAX_ERRORS_RST;
            skip_samples_reg <= SKIP_SAMPLES_RST;
            pulse_cycles_reg <= PULSE_CYCLES_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_WAIT_TIMEOUT: wait_timeout_reg <= cfg_wdata[scbar_pkg::WAIT_W-1:0];
                CFG_READ_TIMEOUT: read_timeout_reg <= cfg_wdata[scbar_pkg::MS_W-1:0];
                CFG_MAX_ERRORS:   max_errors_reg   <= cfg_wdata[scbar_pkg::ERR_W-1:0];
                CFG_SKIP_SAMPLES: skip_samples_reg <= cfg_wdata[scbar_pkg::SKIP_W-1:0];
                CFG_PULSE_CYCLES: pulse_cycles_reg <= cfg_wdata[scbar_pkg::PULSE_W-1:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            bit_index_reg   <= '0;
            pulse_timer_reg <= '0;
            wait_timer_reg  <= '0;
            since_read_reg  <= '0;
            error_count_reg <= '0;
            calib_count_reg <= '0;
            calib_phase_reg <= CAL_NONE;
            updated_reg     <= 1'b0;
            pending_reg     <= 1'b0;
        end
        else if (fire)
        begin
            phase_reg       <= phase_next;
            bit_index_reg   <= bit_index_next;
            pulse_timer_reg <= pulse_timer_next;
            wait_timer_reg  <= wait_timer_next;
            since_read_reg  <= since_read_next;
            error_count_reg <= error_count_next;
            calib_count_reg <= calib_count_next;
            calib_phase_reg <= calib_phase_next;
            updated_reg     <= updated_next;
            pending_reg     <= pending_next;
        end
    end

endmodule

// File: rtl/core/six_channel_bridge_adc_reader_core.sv
// Readout controller for six bridge converters on one shared serial clock. Each
// input item is one sample cycle of the data lines plus edge, millisecond tick,
// acknowledge and calibrate flags; every item yields exactly one result with the
// serial clock level, the six offset-corrected values, the updated flag and the
// status. One item is taken per clock; its result is ready the cycle after it
// is accepted and waits in a two-entry output queue, so input stalls only when
// both entries are full. The six channel lanes run side by side; each lane
// holds a two-stage reciprocal multiply that turns its calibration sum into
// an average while the last clock pulses of a read go out.
module six_channel_bridge_adc_reader_core (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_we,
    input  logic [scbar_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [scbar_pkg::CFG_DATA_W-1:0]        cfg_wdata,
    input  logic                                    in_valid,
    output logic                                    in_ready,
    input  logic [scbar_pkg::CHANNELS-1:0]          data_pins,
    input  logic                                    edge_seen,
    input  logic                                    ms_tick,
    input  logic                                    read_ack,
    input  logic                                    calibrate,
    output logic                                    out_valid,
    input  logic                                    out_ready,
    output logic                                    sclk,
    output logic signed [scbar_pkg::VALUE_W-1:0]    value_ch0,
    output logic signed [scbar_pkg::VALUE_W-1:0]    value_ch1,
    output logic signed [scbar_pkg::VALUE_W-1:0]    value_ch2,
    output logic signed [scbar_pkg::VALUE_W-1:0]    value_ch3,
    output logic signed [scbar_pkg::VALUE_W-1:0]    value_ch4,
    output logic signed [scbar_pkg::VALUE_W-1:0]    value_ch5,
    output logic                                    data_updated,
    output logic [scbar_pkg::STATUS_W-1:0]          status
);

    logic                                   fire;
    logic                                   pop;
    logic                                   all_low;
    logic [scbar_pkg::CHANNELS-1:0]         line_low;
    scbar_pkg::value_t [scbar_pkg::CHANNELS-1:0] lane_values;
    scbar_pkg::lane_ctl_t                   ctl;
    logic                                   sclk_next;
    logic                                   updated_next;
    logic [scbar_pkg::STATUS_W-1:0]         status_next;
    scbar_pkg::result_t                     result;
    scbar_pkg::result_t                     head;

    scbar_pkg::result_t                     entry_reg [2];
    logic                                   wr_ptr_reg, wr_ptr_next;
    logic                                   rd_ptr_reg, rd_ptr_next;
    logic [1:0]                             count_reg, count_next;

    assign in_ready  = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign fire      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;
    assign all_low   = &line_low;

    scbar_seq u_seq (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_we            (cfg_we),
        .cfg_index         (cfg_index),
        .cfg_wdata         (cfg_wdata),
        .fire              (fire),
        .all_low           (all_low),
        .edge_seen         (edge_seen),
        .ms_tick           (ms_tick),
        .read_ack          (read_ack),
        .calibrate         (calibrate),
        .ctl               (ctl),
        .sclk_next         (sclk_next),
        .data_updated_next (updated_next),
        .status_next       (status_next)
    );

    for (genvar g = 0; g < scbar_pkg::CHANNELS; g++)
    begin : g_lane
        scbar_lane u_lane (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctl        (ctl),
            .pin        (data_pins[g]),
            .line_low   (line_low[g]),
            .value_next (lane_values[g])
        );
    end

    always_comb
    begin
        result.sclk         = sclk_next;
        result.values       = lane_values;
        result.data_updated = updated_next;
        result.status       = status_next;
    end

    assign wr_ptr_next = wr_ptr_reg ^ fire;
    assign rd_ptr_next = rd_ptr_reg ^ pop;
    assign count_next  = count_reg + {1'b0, fire} - {1'b0, pop};

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            entry_reg[wr_ptr_reg] <= result;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    assign head         = entry_reg[rd_ptr_reg];
    assign sclk         = head.sclk;
    assign value_ch0    = head.values[0];
    assign value_ch1    = head.values[1];
    assign value_ch2    = head.values[2];
    assign value_ch3    = head.values[3];
    assign value_ch4    = head.values[4];
    assign value_ch5    = head.values[5];
    assign data_updated = head.data_updated;
    assign status       = head.status;

endmodule

// File: rtl/core/scbar_checker.sv
module scbar_checker (
    input logic                                 clk,
    input logic                                 rst_n,
    input logic                                 in_ready,
    input logic                                 out_valid,
    input logic                                 out_ready,
    input logic                                 sclk,
    input logic signed [scbar_pkg::VALUE_W-1:0] value_ch0,
    input logic [scbar_pkg::STATUS_W-1:0]       status
);

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(value_ch0) && $stable(status)
                                    && $stable(sclk))
        else $error("result changed while stalled");

    a_ready_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !$past(out_ready))
        else $error("input stalled with output queue not full");

    a_failed_sclk_high: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == scbar_pkg::ST_FAIL |-> sclk)
        else $error("failed status with serial clock low");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status == scbar_pkg::ST_RUN || status == scbar_pkg::ST_CAL
                      || status == scbar_pkg::ST_FAIL)
        else $error("undefined status code");

endmodule

bind six_channel_bridge_adc_reader_core scbar_checker u_scbar_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sclk      (sclk),
    .value_ch0 (value_ch0),
    .status    (status)
);
